// ===== design/lsmt_pkg.sv =====
// Shared constants and types for the LCD scanline mode timer.
`timescale 1ns / 1ps

package lsmt_pkg;

	localparam int TICK_W  = 8;
	localparam int DOT_W   = 10;
	localparam int LINE_W  = 8;
	localparam int CMP_W   = 8;
	localparam int IRQEN_W = 4;
	localparam int CFGIDX_W = 2;
	localparam int CFGDAT_W = 8;

	localparam logic [DOT_W-1:0]  DOTS_PER_LINE = DOT_W'(456);
	localparam logic [DOT_W-1:0]  OAM_DOTS      = DOT_W'(80);
	localparam logic [DOT_W-1:0]  XFER_END_DOTS = DOT_W'(252);
	localparam logic [LINE_W-1:0] VBLANK_LINE   = LINE_W'(144);
	localparam logic [LINE_W-1:0] LAST_LINE     = LINE_W'(153);

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef enum logic [CFGIDX_W-1:0] {
		REG_LCD_ENABLED  = 2'd0,
		REG_LINE_COMPARE = 2'd1,
		REG_IRQ_ENABLES  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	// interrupt enable bit positions
	localparam int IRQEN_HBLANK = 0;
	localparam int IRQEN_VBLANK = 1;
	localparam int IRQEN_OAM    = 2;
	localparam int IRQEN_COINC  = 3;

endpackage

// ===== design/lcd_scanline_mode_timer.sv =====
// LCD scanline mode timer: dot and line counters, mode, coincidence and interrupts.
//
// Usage: each input item on in_valid/in_ready carries tick_cycles, the dot cycles
// elapsed since the previous item. The block classifies the position held before
// the tick (mode, coincidence, status interrupt), then advances the dot counter
// and, at 456 dots, the line counter. One result item per input item appears on
// out_valid/out_ready in the cycle after acceptance, from the output register.
// Throughput is one item per cycle while out_ready is high: the update is two adds
// and a few compares between the state registers, so the next item is taken at once.
// in_ready is high whenever the output register is empty or is being emptied in
// the same cycle; a stalled receiver holds the result and stops intake after one
// item. Configuration writes on cfg_valid (cfg_ready is always high) take effect
// from the next accepted item; write them only while the block is idle.
// Reset clears the counters, mode, coincidence flag, all configuration registers (LCD disabled)
// and empties the output register.
`timescale 1ns / 1ps

module lcd_scanline_mode_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lsmt_pkg::TICK_W-1:0]       tick_cycles,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lsmt_pkg::LINE_W-1:0]       line,
	output logic [1:0]                        mode,
	output logic                              coincidence,
	output logic                              vblank_irq,
	output logic                              stat_irq,
	output logic                              render_start,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsmt_pkg::CFGIDX_W-1:0]     cfg_index,
	input  logic [lsmt_pkg::CFGDAT_W-1:0]     cfg_data
);

	logic                            lcd_enabled_q;
	logic [lsmt_pkg::CMP_W-1:0]      line_compare_q;
	logic [lsmt_pkg::IRQEN_W-1:0]    irq_en_q;

	logic [lsmt_pkg::DOT_W-1:0]      dot_q;
	logic [lsmt_pkg::LINE_W-1:0]     line_cnt_q;
	lsmt_pkg::mode_t                 mode_q;
	logic                            coinc_q;

	logic                            out_valid_q;
	logic [lsmt_pkg::LINE_W-1:0]     line_q;
	lsmt_pkg::mode_t                 mode_out_q;
	logic                            coinc_out_q;
	logic                            vblank_q;
	logic                            stat_q;
	logic                            render_q;

	logic                            accept;
	lsmt_pkg::mode_t                 mode_cls;
	logic                            mode_irq_en;
	logic                            coinc_hit;
	logic [lsmt_pkg::DOT_W-1:0]      dot_sum;
	logic [lsmt_pkg::LINE_W-1:0]     line_inc;

	logic [lsmt_pkg::DOT_W-1:0]      dot_nxt;
	logic [lsmt_pkg::LINE_W-1:0]     line_nxt;
	lsmt_pkg::mode_t                 mode_nxt;
	logic                            coinc_nxt;
	logic                            vblank_nxt;
	logic                            stat_nxt;
	logic                            render_nxt;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_enabled_q  <= 1'b0;
			line_compare_q <= '0;
			irq_en_q       <= '0;
		end else if (cfg_valid) begin
			unique case (lsmt_pkg::reg_idx_t'(cfg_index))
				lsmt_pkg::REG_LCD_ENABLED:  lcd_enabled_q  <= cfg_data[0];
				lsmt_pkg::REG_LINE_COMPARE: line_compare_q <= cfg_data;
				lsmt_pkg::REG_IRQ_ENABLES:  irq_en_q       <= cfg_data[lsmt_pkg::IRQEN_W-1:0];
				default: ;
			endcase
		end
	end

	// classify the position held before the tick
	always_comb begin
		if (line_cnt_q >= lsmt_pkg::VBLANK_LINE)
			mode_cls = lsmt_pkg::MODE_VBLANK;
		else if (dot_q < lsmt_pkg::OAM_DOTS)
			mode_cls = lsmt_pkg::MODE_OAM;
		else if (dot_q < lsmt_pkg::XFER_END_DOTS)
			mode_cls = lsmt_pkg::MODE_XFER;
		else
			mode_cls = lsmt_pkg::MODE_HBLANK;
	end

	always_comb begin
		unique case (mode_cls)
			lsmt_pkg::MODE_HBLANK: mode_irq_en = irq_en_q[lsmt_pkg::IRQEN_HBLANK];
			lsmt_pkg::MODE_VBLANK: mode_irq_en = irq_en_q[lsmt_pkg::IRQEN_VBLANK];
			lsmt_pkg::MODE_OAM:    mode_irq_en = irq_en_q[lsmt_pkg::IRQEN_OAM];
			default:               mode_irq_en = 1'b0;
		endcase
	end

	assign coinc_hit = (line_cnt_q == line_compare_q);
	// dot counter stays below 456, so 455 + 255 fits in ten bits
	assign dot_sum   = dot_q + lsmt_pkg::DOT_W'(tick_cycles);
	assign line_inc  = line_cnt_q + 1'b1;

	always_comb begin
		dot_nxt    = dot_sum;
		line_nxt   = line_cnt_q;
		mode_nxt   = mode_cls;
		coinc_nxt  = coinc_hit;
		vblank_nxt = 1'b0;
		render_nxt = 1'b0;
		stat_nxt   = ((mode_cls != mode_q) && mode_irq_en) ||
			(coinc_hit && irq_en_q[lsmt_pkg::IRQEN_COINC]);
		if (dot_sum >= lsmt_pkg::DOTS_PER_LINE) begin
			dot_nxt = '0;
			if (line_inc == lsmt_pkg::VBLANK_LINE) begin
				line_nxt   = line_inc;
				vblank_nxt = 1'b1;
			end else if (line_inc > lsmt_pkg::LAST_LINE) begin
				line_nxt = '0;
			end else begin
				line_nxt   = line_inc;
				render_nxt = (line_inc < lsmt_pkg::VBLANK_LINE);
			end
		end
		if (!lcd_enabled_q) begin
			dot_nxt    = '0;
			line_nxt   = '0;
			mode_nxt   = lsmt_pkg::MODE_VBLANK;
			coinc_nxt  = coinc_q;
			vblank_nxt = 1'b0;
			stat_nxt   = 1'b0;
			render_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q      <= '0;
			line_cnt_q <= '0;
			mode_q     <= lsmt_pkg::MODE_HBLANK;
			coinc_q    <= 1'b0;
		end else if (accept) begin
			dot_q      <= dot_nxt;
			line_cnt_q <= line_nxt;
			mode_q     <= mode_nxt;
			coinc_q    <= coinc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q      <= line_nxt;
			mode_out_q  <= mode_nxt;
			coinc_out_q <= coinc_nxt;
			vblank_q    <= vblank_nxt;
			stat_q      <= stat_nxt;
			render_q    <= render_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign line         = line_q;
	assign mode         = mode_out_q;
	assign coincidence  = coinc_out_q;
	assign vblank_irq   = vblank_q;
	assign stat_irq     = stat_q;
	assign render_start = render_q;

	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q < lsmt_pkg::DOTS_PER_LINE)
		else $error("dot counter beyond line length");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_cnt_q <= lsmt_pkg::LAST_LINE)
		else $error("line counter beyond last line");

	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && vblank_q) |-> (line_q == lsmt_pkg::VBLANK_LINE && !render_q))
		else $error("vblank pulse away from line 144");

	a_render_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && render_q) |-> (line_q != '0 && line_q < lsmt_pkg::VBLANK_LINE))
		else $error("render start outside visible lines");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(line_q) && $stable(stat_q)))
		else $error("result lost while receiver stalled");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !lcd_enabled_q) |=> (line_cnt_q == '0 && dot_q == '0 &&
			mode_q == lsmt_pkg::MODE_VBLANK))
		else $error("counters not held while display disabled");

endmodule

// ===== verif/tb_lcd_scanline_mode_timer.sv =====
// Testbench for the LCD scanline mode timer: predicts line, mode and interrupt outputs per tick.
`timescale 1ns / 1ps

typedef struct packed {
	logic [lsmt_pkg::LINE_W-1:0] line;
	logic [1:0]                  mode;
	logic                        coin;
	logic                        vblank;
	logic                        stat;
	logic                        render;
} lcd_status_t;

typedef enum int unsigned {TICKS_ANY, TICKS_LONG, TICKS_SHORT} tick_mix_t;

class lcd_timing_scoreboard;
	logic                         lcd_en;
	logic [lsmt_pkg::CMP_W-1:0]   cmp;
	logic [lsmt_pkg::IRQEN_W-1:0] irq_en;
	logic [lsmt_pkg::DOT_W-1:0]   dot;
	logic [lsmt_pkg::LINE_W-1:0]  ln;
	lsmt_pkg::mode_t              mode_q;
	logic                         coin;
	lcd_status_t                  expected_status[$];
	int unsigned                  mismatches;

	function new();
		lcd_en = 1'b0;
		cmp = '0;
		irq_en = '0;
		dot = '0;
		ln = '0;
		mode_q = lsmt_pkg::MODE_HBLANK;
		coin = 1'b0;
		mismatches = 0;
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function void write_reg(lsmt_pkg::reg_idx_t idx, logic [lsmt_pkg::CFGDAT_W-1:0] data);
		case (idx)
			lsmt_pkg::REG_LCD_ENABLED:  lcd_en = data[0];
			lsmt_pkg::REG_LINE_COMPARE: cmp = data;
			lsmt_pkg::REG_IRQ_ENABLES:  irq_en = data[lsmt_pkg::IRQEN_W-1:0];
			default: ;
		endcase
	endfunction

	function lsmt_pkg::mode_t classify();
		if (ln >= lsmt_pkg::VBLANK_LINE) return lsmt_pkg::MODE_VBLANK;
		if (dot < lsmt_pkg::OAM_DOTS) return lsmt_pkg::MODE_OAM;
		if (dot < lsmt_pkg::XFER_END_DOTS) return lsmt_pkg::MODE_XFER;
		return lsmt_pkg::MODE_HBLANK;
	endfunction

	// transfer mode has no enable of its own
	function logic mode_irq_on(lsmt_pkg::mode_t m);
		case (m)
			lsmt_pkg::MODE_HBLANK: return irq_en[lsmt_pkg::IRQEN_HBLANK];
			lsmt_pkg::MODE_VBLANK: return irq_en[lsmt_pkg::IRQEN_VBLANK];
			lsmt_pkg::MODE_OAM:    return irq_en[lsmt_pkg::IRQEN_OAM];
			default:               return 1'b0;
		endcase
	endfunction

	function void note_tick(logic [lsmt_pkg::TICK_W-1:0] ticks);
		lcd_status_t r;
		lsmt_pkg::mode_t m;
		r = '0;
		if (!lcd_en) begin
			dot = '0;
			ln = '0;
			mode_q = lsmt_pkg::MODE_VBLANK;
		end else begin
			m = classify();
			if (m != mode_q && mode_irq_on(m))
				r.stat = 1'b1;
			mode_q = m;
			coin = (ln == cmp);
			if (coin && irq_en[lsmt_pkg::IRQEN_COINC])
				r.stat = 1'b1;
			dot = dot + lsmt_pkg::DOT_W'(ticks);
			// excess dots beyond the line length are dropped
			if (dot >= lsmt_pkg::DOTS_PER_LINE) begin
				dot = '0;
				ln = ln + 1'b1;
				if (ln == lsmt_pkg::VBLANK_LINE)
					r.vblank = 1'b1;
				else if (ln > lsmt_pkg::LAST_LINE)
					ln = '0;
				else if (ln < lsmt_pkg::VBLANK_LINE)
					r.render = 1'b1;
			end
		end
		r.line = ln;
		r.mode = mode_q;
		r.coin = coin;
		expected_status.push_back(r);
	endfunction

	task check_status(lcd_status_t got);
		lcd_status_t want;
		if (expected_status.size() == 0) begin
			report($sformatf("unexpected result line=%0d mode=%0d", got.line, got.mode));
			return;
		end
		want = expected_status.pop_front();
		if (got.line !== want.line)
			report($sformatf("line %0d, want %0d", got.line, want.line));
		if (got.mode !== want.mode)
			report($sformatf("mode %0d, want %0d (line %0d)", got.mode, want.mode, want.line));
		if (got.coin !== want.coin)
			report($sformatf("coincidence %b, want %b (line %0d)", got.coin, want.coin, want.line));
		if (got.vblank !== want.vblank)
			report($sformatf("vblank_irq %b, want %b (line %0d)", got.vblank, want.vblank,
				want.line));
		if (got.stat !== want.stat)
			report($sformatf("stat_irq %b, want %b (line %0d mode %0d)", got.stat, want.stat,
				want.line, want.mode));
		if (got.render !== want.render)
			report($sformatf("render_start %b, want %b (line %0d)", got.render, want.render,
				want.line));
	endtask
endclass

module tb_lcd_scanline_mode_timer;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned PHASE_ITEMS = 105;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [lsmt_pkg::TICK_W-1:0] tick_cycles;
	logic out_valid;
	logic out_ready;
	logic [lsmt_pkg::LINE_W-1:0] line;
	logic [1:0] mode;
	logic coincidence;
	logic vblank_irq;
	logic stat_irq;
	logic render_start;
	logic cfg_valid;
	logic cfg_ready;
	logic [lsmt_pkg::CFGIDX_W-1:0] cfg_index;
	logic [lsmt_pkg::CFGDAT_W-1:0] cfg_data;

	lcd_timing_scoreboard sb;
	int unsigned cycle_count = 0;

	lcd_scanline_mode_timer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tick_cycles(tick_cycles),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line(line),
		.mode(mode),
		.coincidence(coincidence),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.render_start(render_start),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// results first, then register writes, then new items
	always @(posedge clk) begin : monitor
		lcd_status_t got;
		if (arst_n === 1'b1) begin
			got = {line, mode, coincidence, vblank_irq, stat_irq, render_start};
			if (out_valid === 1'b1 && out_ready)
				sb.check_status(got);
			if (cfg_valid && cfg_ready === 1'b1)
				sb.write_reg(lsmt_pkg::reg_idx_t'(cfg_index), cfg_data);
			if (in_valid && in_ready === 1'b1)
				sb.note_tick(tick_cycles);
		end
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [lsmt_pkg::TICK_W-1:0] pick_tick(tick_mix_t mix);
		case (mix)
			TICKS_LONG:
				return ($urandom_range(0, 7) == 0) ? lsmt_pkg::TICK_W'($urandom)
					: lsmt_pkg::TICK_W'($urandom_range(200, 255));
			TICKS_SHORT: return lsmt_pkg::TICK_W'($urandom_range(0, 63));
			default:     return lsmt_pkg::TICK_W'($urandom);
		endcase
	endfunction

	// receiver: random stalls, occasionally a long run of steady ready
	initial begin : receiver
		int unsigned hold;
		int unsigned run;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = gap_len();
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
		end
	end

	// valid stays high into the next item when no gap follows
	task automatic send_tick(logic [lsmt_pkg::TICK_W-1:0] t, int unsigned gap);
		in_valid <= 1'b1;
		tick_cycles <= t;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_status.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// writes all registers, plus the unused index with junk data
	task automatic set_regs(logic en, logic [lsmt_pkg::CMP_W-1:0] cmpv,
		logic [lsmt_pkg::IRQEN_W-1:0] irq);
		logic [lsmt_pkg::CFGDAT_W-1:0] vals [4];
		vals[lsmt_pkg::REG_LCD_ENABLED]  = {7'($urandom), en};
		vals[lsmt_pkg::REG_LINE_COMPARE] = cmpv;
		vals[lsmt_pkg::REG_IRQ_ENABLES]  = {4'($urandom), irq};
		vals[lsmt_pkg::REG_UNUSED]       = lsmt_pkg::CFGDAT_W'($urandom);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= lsmt_pkg::reg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (cfg_ready !== 1'b1) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		tick_mix_t mix;
		logic [lsmt_pkg::CMP_W-1:0] cmpv;
		logic [lsmt_pkg::IRQEN_W-1:0] irq;
		logic en;
		int unsigned n_items;
		logic steady;

		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		tick_cycles <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= lsmt_pkg::REG_LCD_ENABLED;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// display off: held at line 0 in vblank whatever the tick
		set_regs(1'b0, 8'd255, 4'hF);
		send_tick(8'd0, 0);
		send_tick(8'd255, 0);
		send_tick(8'd7, 0);
		drain();

		// walk through the mode boundaries, then a line end and an oversized tick
		set_regs(1'b1, 8'd0, 4'hF);
		send_tick(8'd0, 0);
		send_tick(8'd79, 0);
		send_tick(8'd1, 0);
		send_tick(8'd171, 0);
		send_tick(8'd1, 0);
		send_tick(8'd203, 0);
		send_tick(8'd1, 0);
		send_tick(8'd255, 0);
		send_tick(8'd255, 0);
		send_tick(8'd0, 0);
		drain();

		// coincidence alone: interrupt repeats on every step at the matching line
		set_regs(1'b1, 8'd2, 4'h8);
		send_tick(8'd0, 0);
		send_tick(8'd0, 1);
		send_tick(8'd0, 0);
		drain();

		// off phase first so later phases run unbroken across a frame wrap
		for (int ph = 0; ph < 9; ph++) begin
			en = (ph != 0);
			case (ph)
				1: irq = 4'hF;
				2: irq = 4'h0;
				default: irq = 4'($urandom_range(0, 15));
			endcase
			case (ph)
				1: cmpv = 8'd255;
				2: cmpv = 8'd0;
				3: cmpv = lsmt_pkg::VBLANK_LINE;
				4: cmpv = lsmt_pkg::LAST_LINE;
				default: cmpv = ($urandom_range(0, 3) == 0) ? lsmt_pkg::CMP_W'($urandom)
					: lsmt_pkg::CMP_W'($urandom_range(0, 153));
			endcase
			case (ph % 4)
				1: mix = TICKS_ANY;
				3: mix = (ph == 3) ? TICKS_SHORT : TICKS_ANY;
				default: mix = TICKS_LONG;
			endcase
			n_items = (ph == 0) ? 30 : PHASE_ITEMS;
			steady = (ph == 6);
			set_regs(en, cmpv, irq);
			for (int k = 0; k < n_items; k++)
				send_tick(pick_tick(mix), steady ? 0 : gap_len());
			drain();
		end

		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== lcd_scanline_mode_timer.f =====
design/lsmt_pkg.sv
design/lcd_scanline_mode_timer.sv
verif/tb_lcd_scanline_mode_timer.sv
